### rtl/core/caa_pkg.sv
package caa_pkg;

  localparam int LABEL_W = 10;
  localparam int AFF_W   = 16;
  localparam int WGT_W   = 16;
  localparam int PROD_W  = AFF_W + WGT_W;
  localparam int WSUM_W  = 40;
  localparam int PSUM_W  = 56;
  localparam int CFG_W   = 10;

  // quotient bits produced by the divider, one per step
  localparam int DIV_STEPS = AFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_IGNORE_ENABLE = 1'b0;
  localparam logic CFG_IGNORE_LABEL  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [LABEL_W-1:0] label_u;
    logic [LABEL_W-1:0] label_v;
    logic               neighbor_inside;
    logic [AFF_W-1:0]   affinity;
    logic [WGT_W-1:0]   weight;
  } item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label_out;
    logic [AFF_W-1:0]   mean_affinity;
    logic [AFF_W-1:0]   max_affinity;
    logic [WSUM_W-1:0]  weight_total;
  } result_t;

  typedef struct packed {
    logic [AFF_W-1:0]  max_aff;
    logic [WSUM_W-1:0] wsum;
    logic [PSUM_W-1:0] psum;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC_MUL,
    S_ACC_WR,
    S_RD_LOAD,
    S_RD_DIV
  } state_t;

endpackage

### rtl/core/cluster_affinity_accumulator.sv
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+---------------------------------
// command  | start, busy, item                  | taken when start & !busy
// result   | done, result                       | valid while done, one cycle only
// config   | cfg_we, cfg_index, cfg_data        | written when cfg_we
//
// An accumulate transaction passes through accept, multiply and a saturating
// read-modify-write of the label entry; a dropped sample never leaves idle.
// A read transaction runs the bit-serial divider (one overflow test plus 16
// quotient steps); an out-of-range read is answered with zero statistics.
// After reset the entry store is cleared one entry a cycle, all min(NUM_LABELS,
// 1024) entries, with busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result shows on done for one cycle.
module cluster_affinity_accumulator #(
  parameter int NUM_LABELS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  caa_pkg::item_t                item,
  output logic                          done,
  output caa_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [caa_pkg::CFG_W-1:0]     cfg_data
);
  import caa_pkg::*;

  localparam int LABEL_SPAN = 1 << LABEL_W;
  localparam int MEM_DEPTH  = (NUM_LABELS < LABEL_SPAN) ? NUM_LABELS : LABEL_SPAN;
  localparam int ADDR_W     = (MEM_DEPTH > 2) ? $clog2(MEM_DEPTH) : 1;

  state_t state, state_next;

  logic               ignore_enable;
  logic [LABEL_W-1:0] ignore_label;

  item_t              item_r;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  clr_addr;

  logic               accept;
  logic               in_range;
  logic               acc_ok;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wr_addr;
  entry_t             mem_wr_data;
  logic [ADDR_W-1:0]  mem_rd_addr;
  entry_t             mem_rd_data;

  logic               div_start;
  logic               div_done;
  logic [AFF_W-1:0]   div_quotient;

  logic [WSUM_W:0]    wsum_add;
  logic [PSUM_W:0]    psum_add;
  logic [AFF_W-1:0]   max_new;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(item.label_u) < NUM_LABELS);
  assign acc_ok   = item.neighbor_inside && (item.label_u == item.label_v) && in_range &&
                    !(ignore_enable && (item.label_u == ignore_label));

  // saturating updates of the fetched entry
  always_comb begin
    wsum_add = {1'b0, mem_rd_data.wsum} + (WSUM_W + 1)'(item_r.weight);
    psum_add = {1'b0, mem_rd_data.psum} + (PSUM_W + 1)'(prod);
    max_new  = (item_r.affinity > mem_rd_data.max_aff) ? item_r.affinity
                                                        : mem_rd_data.max_aff;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_READ) begin
            if (in_range) state_next = S_RD_LOAD;
          end else if (acc_ok) begin
            state_next = S_ACC_MUL;
          end
        end
      end
      S_ACC_MUL: state_next = S_ACC_WR;
      S_ACC_WR:  state_next = S_IDLE;
      S_RD_LOAD: state_next = S_RD_DIV;
      S_RD_DIV: begin
        if (div_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = item_r.label_u[ADDR_W-1:0];
    mem_wr_data = '{max_aff: max_new,
                    wsum:    wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0],
                    psum:    psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0]};
    mem_rd_addr = item_r.label_u[ADDR_W-1:0];
    div_start   = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      S_IDLE:    mem_rd_addr = item.label_u[ADDR_W-1:0];
      S_ACC_WR:  mem_we      = 1'b1;
      S_RD_LOAD: div_start   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      done          <= 1'b0;
      ignore_enable <= 1'b0;
      ignore_label  <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IGNORE_ENABLE: ignore_enable <= cfg_data[0];
          CFG_IGNORE_LABEL:  ignore_label  <= cfg_data[LABEL_W-1:0];
          default: ;
        endcase
      end
      // out-of-range read: answer at once with zero statistics
      if (accept && item.op == OP_READ && !in_range) done <= 1'b1;
      if (state == S_RD_DIV && div_done) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= item;
    if (state == S_ACC_MUL) prod <= item_r.affinity * item_r.weight;
    if (accept && item.op == OP_READ && !in_range) begin
      result <= '{label_out: item.label_u, mean_affinity: '0,
                  max_affinity: '0, weight_total: '0};
    end else if (state == S_RD_DIV && div_done) begin
      result <= '{label_out:     item_r.label_u,
                  mean_affinity: div_quotient,
                  max_affinity:  mem_rd_data.max_aff,
                  weight_total:  mem_rd_data.wsum};
    end
  end

  caa_entry_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  caa_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (mem_rd_data.psum),
    .denominator (mem_rd_data.wsum),
    .done        (div_done),
    .quotient    (div_quotient)
  );

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RD_DIV || (state == S_IDLE && start)))
    else $error("result strobe without a read transaction");

  a_div_only_in_read: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_RD_DIV)
    else $error("divider finished outside a read");

  a_write_follows_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC_WR) |-> $past(state == S_ACC_MUL))
    else $error("entry update without a product");

endmodule

### rtl/core/caa_entry_mem.sv
module caa_entry_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  caa_pkg::entry_t     wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output caa_pkg::entry_t     rd_data
);
  import caa_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/caa_div.sv
module caa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [caa_pkg::PSUM_W-1:0]  numerator,
  input  logic [caa_pkg::WSUM_W-1:0]  denominator,
  output logic                        done,
  output logic [caa_pkg::AFF_W-1:0]   quotient
);
  import caa_pkg::*;

  logic [WSUM_W:0]      rem;
  logic [AFF_W-1:0]     low;
  logic [WSUM_W-1:0]    den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 active;
  logic                 first;

  logic [WSUM_W:0]   opa;
  logic [WSUM_W+1:0] diff;
  logic              ge;

  // one shared subtractor: the first pass tests for overflow of the quotient,
  // then each pass brings down one numerator bit
  always_comb begin
    opa  = first ? rem : {rem[WSUM_W-1:0], low[AFF_W-1]};
    diff = {1'b0, opa} - {2'b00, den};
    ge   = ~diff[WSUM_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= {1'b0, numerator[PSUM_W-1:AFF_W]};
        low      <= numerator[AFF_W-1:0];
        den      <= denominator;
        quotient <= '0;
        cnt      <= DIV_CNT_W'(DIV_STEPS);
        first    <= 1'b1;
        active   <= (denominator != '0);
        // zero weight: mean reads as zero
        done     <= (denominator == '0);
      end else if (active) begin
        if (first) begin
          first <= 1'b0;
          if (ge) begin
            quotient <= '1;
            active   <= 1'b0;
            done     <= 1'b1;
          end
        end else begin
          rem      <= ge ? diff[WSUM_W:0] : opa;
          low      <= {low[AFF_W-2:0], 1'b0};
          quotient <= {quotient[AFF_W-2:0], ge};
          cnt      <= cnt - 1'b1;
          if (cnt == DIV_CNT_W'(1)) begin
            active <= 1'b0;
            done   <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import caa_pkg::*;

  localparam int N_LABELS     = 1024;
  localparam int ITEM_TARGET  = 1950;
  localparam int N_PHASES     = 6;
  localparam int IDLE_DRAIN   = 8;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 400000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             done;
  result_t          result;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  typedef struct {
    bit               is_cfg;
    logic             cfg_sel;
    logic [CFG_W-1:0] cfg_val;
    item_t            it;
    bit               fixed;
    result_t          fixed_res;
  } step_t;

  // mirror of the label statistics and the ignore registers
  logic [AFF_W-1:0]   max_aff_tab  [N_LABELS];
  logic [WSUM_W-1:0]  wt_total_tab [N_LABELS];
  logic [PSUM_W-1:0]  wprod_tab    [N_LABELS];
  logic               ign_en;
  logic [LABEL_W-1:0] ign_label;

  result_t pending_reads [$];
  result_t want;
  int      err_count = 0;
  int      cycle_count = 0;

  cluster_affinity_accumulator #(.NUM_LABELS(N_LABELS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit update_label_stats(input item_t it, output result_t r);
    logic [LABEL_W-1:0] lu;
    logic [WSUM_W:0]    wt_next;
    logic [PSUM_W:0]    prod_next;
    logic [PROD_W-1:0]  prod;
    logic [PSUM_W-1:0]  quot;
    lu = it.label_u;
    r = '0;
    r.label_out = lu;
    if (it.op == OP_READ) begin
      if (wt_total_tab[lu] != '0) begin
        quot = wprod_tab[lu] / wt_total_tab[lu];
        r.mean_affinity = (quot > PSUM_W'(16'hFFFF)) ? '1 : quot[AFF_W-1:0];
      end
      r.max_affinity = max_aff_tab[lu];
      r.weight_total = wt_total_tab[lu];
      return 1'b1;
    end
    if (it.neighbor_inside && it.label_u == it.label_v && !(ign_en && lu == ign_label)) begin
      if (it.affinity > max_aff_tab[lu]) max_aff_tab[lu] = it.affinity;
      prod = it.affinity * it.weight;
      wt_next = {1'b0, wt_total_tab[lu]} + it.weight;
      prod_next = {1'b0, wprod_tab[lu]} + prod;
      // clamp both sums at all ones
      wt_total_tab[lu] = wt_next[WSUM_W] ? '1 : wt_next[WSUM_W-1:0];
      wprod_tab[lu] = prod_next[PSUM_W] ? '1 : prod_next[PSUM_W-1:0];
    end
    return 1'b0;
  endfunction

  function automatic step_t item_step(input logic op, input logic [LABEL_W-1:0] lu,
                                      input logic [LABEL_W-1:0] lv, input logic nb_in,
                                      input logic [AFF_W-1:0] aff,
                                      input logic [WGT_W-1:0] wt);
    step_t s;
    s.is_cfg = 1'b0;
    s.cfg_sel = CFG_IGNORE_ENABLE;
    s.cfg_val = '0;
    s.it.op = op;
    s.it.label_u = lu;
    s.it.label_v = lv;
    s.it.neighbor_inside = nb_in;
    s.it.affinity = aff;
    s.it.weight = wt;
    s.fixed = 1'b0;
    s.fixed_res = '0;
    return s;
  endfunction

  // read of a label with its statistics typed in
  function automatic step_t read_known(input logic [LABEL_W-1:0] lu,
                                       input logic [AFF_W-1:0] mean,
                                       input logic [AFF_W-1:0] mx,
                                       input logic [WSUM_W-1:0] wt_tot);
    step_t s;
    s = item_step(OP_READ, lu, LABEL_W'($urandom), 1'($urandom), AFF_W'($urandom),
                  WGT_W'($urandom));
    s.fixed = 1'b1;
    s.fixed_res.label_out = lu;
    s.fixed_res.mean_affinity = mean;
    s.fixed_res.max_affinity = mx;
    s.fixed_res.weight_total = wt_tot;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic sel, input logic [CFG_W-1:0] val);
    step_t s;
    s = item_step(OP_ACC, '0, '0, 1'b0, '0, '0);
    s.is_cfg = 1'b1;
    s.cfg_sel = sel;
    s.cfg_val = val;
    return s;
  endfunction

  // caller stands at a falling edge; returns at a falling edge
  task automatic send_item(input item_t it, input int gap, input bit fixed,
                           input result_t fixed_res);
    bit      taken;
    result_t r;
    item = it;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    if (update_label_stats(it, r)) pending_reads.push_back(fixed ? fixed_res : r);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
    start = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    // let a trailing accumulate finish its write-back
    repeat (IDLE_DRAIN) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (sel == CFG_IGNORE_ENABLE) ign_en = val[0];
    else ign_label = val[LABEL_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing expected, got %p", $time, result);
      end else begin
        want = pending_reads.pop_front();
        if (result.label_out !== want.label_out) begin
          err_count++;
          $display("%0t: label_out expected %0d got %0d", $time, want.label_out,
                   result.label_out);
        end
        if (result.mean_affinity !== want.mean_affinity) begin
          err_count++;
          $display("%0t: label %0d mean_affinity expected %h got %h", $time,
                   want.label_out, want.mean_affinity, result.mean_affinity);
        end
        if (result.max_affinity !== want.max_affinity) begin
          err_count++;
          $display("%0t: label %0d max_affinity expected %h got %h", $time,
                   want.label_out, want.max_affinity, result.max_affinity);
        end
        if (result.weight_total !== want.weight_total) begin
          err_count++;
          $display("%0t: label %0d weight_total expected %h got %h", $time,
                   want.label_out, want.weight_total, result.weight_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** cluster_affinity_accumulator: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    step_t              plan [$];
    item_t              it;
    logic [LABEL_W-1:0] hot [8];
    logic [LABEL_W-1:0] lab;
    logic               en;
    int                 roll;
    int                 gap;
    int                 counted;
    int                 n;
    bit                 burst;
    result_t            none;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_IGNORE_ENABLE;
    cfg_data = '0;
    ign_en = 1'b0;
    ign_label = '0;
    none = '0;
    for (int i = 0; i < N_LABELS; i++) begin
      max_aff_tab[i] = '0;
      wt_total_tab[i] = '0;
      wprod_tab[i] = '0;
    end
    hot[0] = '0;
    hot[1] = '1;
    for (int i = 2; i < 8; i++) hot[i] = LABEL_W'($urandom);

    // empty entries, then the extremes of affinity and weight
    plan.push_back(read_known(10'd0, '0, '0, '0));
    plan.push_back(read_known(10'd1023, '0, '0, '0));
    plan.push_back(item_step(OP_ACC, 10'd5, 10'd5, 1'b1, 16'hFFFF, 16'hFFFF));
    plan.push_back(read_known(10'd5, 16'hFFFF, 16'hFFFF, 40'hFFFF));
    // labels differ, then neighbour outside: both dropped
    plan.push_back(item_step(OP_ACC, 10'd6, 10'd7, 1'b1, 16'h1234, 16'h0100));
    plan.push_back(item_step(OP_ACC, 10'd6, 10'd6, 1'b0, 16'h1234, 16'h0100));
    plan.push_back(read_known(10'd6, '0, '0, '0));
    // zero weight: maximum moves, mean stays zero
    plan.push_back(item_step(OP_ACC, 10'd1023, 10'd1023, 1'b1, 16'h0000, 16'h0000));
    plan.push_back(read_known(10'd1023, '0, '0, '0));
    plan.push_back(item_step(OP_ACC, 10'd1023, 10'd1023, 1'b1, 16'h8000, 16'h0000));
    plan.push_back(read_known(10'd1023, '0, 16'h8000, '0));
    plan.push_back(item_step(OP_ACC, 10'd2, 10'd2, 1'b1, 16'h0000, 16'hFFFF));
    plan.push_back(item_step(OP_ACC, 10'd2, 10'd2, 1'b1, 16'h0001, 16'h0001));
    plan.push_back(item_step(OP_ACC, 10'd2, 10'd2, 1'b1, 16'hFFFF, 16'h0001));
    plan.push_back(item_step(OP_READ, 10'd2, 10'd0, 1'b0, '0, '0));
    // ignore rule on label 9
    plan.push_back(cfg_step(CFG_IGNORE_LABEL, 10'd9));
    plan.push_back(cfg_step(CFG_IGNORE_ENABLE, 10'h3FF));
    plan.push_back(item_step(OP_ACC, 10'd9, 10'd9, 1'b1, 16'h1000, 16'h0100));
    plan.push_back(read_known(10'd9, '0, '0, '0));
    plan.push_back(item_step(OP_ACC, 10'd10, 10'd10, 1'b1, 16'h2000, 16'h0100));
    plan.push_back(item_step(OP_READ, 10'd10, 10'd10, 1'b1, 16'hFFFF, 16'hFFFF));
    plan.push_back(cfg_step(CFG_IGNORE_ENABLE, 10'h000));
    plan.push_back(item_step(OP_ACC, 10'd9, 10'd9, 1'b1, 16'h3000, 16'h0200));
    plan.push_back(cfg_step(CFG_IGNORE_ENABLE, 10'h001));
    // a read is answered even for the ignored label
    plan.push_back(item_step(OP_READ, 10'd9, 10'd3, 1'b1, 16'h5555, 16'hAAAA));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].cfg_sel, plan[i].cfg_val);
      else send_item(plan[i].it, $urandom_range(0, 13), plan[i].fixed, plan[i].fixed_res);
    end

    burst = 1'b0;
    n = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin en = 1'b1; lab = '0;     end
        1: begin en = 1'b1; lab = '1;     end
        2: begin en = 1'b0; lab = hot[2]; end
        3: begin en = 1'b1; lab = hot[3]; end
        4: begin en = 1'b1; lab = hot[4]; end
        default: begin en = 1'($urandom); lab = LABEL_W'($urandom); end
      endcase
      write_reg(CFG_IGNORE_ENABLE, {(CFG_W-1)'($urandom), en});
      write_reg(CFG_IGNORE_LABEL, lab);

      counted = 0;
      while (counted < ITEM_TARGET / N_PHASES) begin
        if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
        n++;
        roll = $urandom_range(0, 99);
        it.op = OP_ACC;
        it.label_u = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom) : hot[$urandom_range(0, 7)];
        it.label_v = it.label_u;
        it.neighbor_inside = 1'b1;
        case ($urandom_range(0, 9))
          0: it.affinity = '0;
          1: it.affinity = '1;
          default: it.affinity = AFF_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: it.weight = '0;
          1: it.weight = '1;
          2: it.weight = WGT_W'($urandom_range(1, 255));
          default: it.weight = WGT_W'($urandom);
        endcase
        if (roll < 14) begin
          it.op = OP_READ;
          it.label_v = LABEL_W'($urandom);
          it.neighbor_inside = 1'($urandom);
        end else if (roll >= 84) begin
          // noise: mostly mismatched labels or a neighbour outside
          it.label_v = ($urandom_range(0, 3) == 0) ? it.label_u : LABEL_W'($urandom);
          it.neighbor_inside = 1'($urandom);
        end
        counted++;
        gap = burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
        send_item(it, gap, 1'b0, none);
      end
    end

    start = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) $display("** cluster_affinity_accumulator: PASSED **");
    else $display("** cluster_affinity_accumulator: FAILED **");
    $finish;
  end

endmodule
